// ----- rtl/core/dpc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the distance PID controller: field widths, register indexes
// and the structs passed between pipeline stages. No dependencies.
package dpc_pkg;

  localparam int unsigned POS_W      = 24;
  localparam int unsigned ERR_W      = 25;
  localparam int unsigned DIFF_W     = 26;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned SPEED_W    = 7;
  localparam int unsigned BAND_W     = 23;
  localparam int unsigned PROD_P_W   = 41;
  localparam int unsigned PROD_D_W   = 42;
  localparam int unsigned INTEG_W    = 40;
  localparam int unsigned ACC_W      = 42;
  localparam int unsigned SUM_W      = 43;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned DRV_W      = SUM_W - FRAC_W;
  localparam int unsigned DRIVE_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  localparam logic signed [DRIVE_W-1:0] ONE_PERCENT = 16'sd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 3'd0,
    REG_GAIN_P = 3'd1,
    REG_GAIN_I = 3'd2,
    REG_GAIN_D = 3'd3,
    REG_SPEED  = 3'd4,
    REG_WINDOW = 3'd5,
    REG_SETTLE = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [POS_W-1:0] target;
    logic [GAIN_W-1:0]       gain_p;
    logic [GAIN_W-1:0]       gain_i;
    logic [GAIN_W-1:0]       gain_d;
    logic [SPEED_W-1:0]      max_speed;
    logic [BAND_W-1:0]       window;
    logic [BAND_W-1:0]       band;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic                     start;
    logic                     win;
    logic                     settle;
  } err_t;

  typedef struct packed {
    logic signed [PROD_P_W-1:0] p;
    logic signed [PROD_D_W-1:0] d;
    logic signed [PROD_P_W-1:0] ip;
    logic                       start;
    logic                       win;
    logic                       settle;
  } mul_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]   pd;
    logic signed [INTEG_W-1:0] integ;
    logic                      settle;
  } acc_t;

endpackage

// ----- rtl/core/dpc_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for position samples and drive results.
// Depends on dpc_pkg.
interface dpc_in_if import dpc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position;
  logic                    start_move;

  modport source (output valid, output position, output start_move, input ready);
  modport sink   (input valid, input position, input start_move, output ready);
endinterface

interface dpc_out_if import dpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_level;
  logic                      move_done;

  modport source (output valid, output drive_level, output move_done, input ready);
  modport sink   (input valid, input drive_level, input move_done, output ready);
endinterface

// ----- rtl/core/dpc_err.sv -----
`timescale 1ns / 1ps
// Stage 1: position error, error difference, window and band flags.
// Holds the previous error. Depends on dpc_pkg.
module dpc_err import dpc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    in_valid_i,
  input  logic signed [POS_W-1:0] in_position_i,
  input  logic                    in_start_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  output err_t                    out_data_o,
  input  logic                    out_ready_i
);

  logic                     valid_q;
  err_t                     data_q, data_d;
  logic signed [ERR_W-1:0]  prev_q;
  logic signed [ERR_W-1:0]  prev_sel;
  logic [ERR_W-1:0]         abs_err;
  logic                     take;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    data_d.err    = ERR_W'(cfg_i.target) - ERR_W'(in_position_i);
    prev_sel      = in_start_i ? '0 : prev_q;
    data_d.diff   = DIFF_W'(data_d.err) - DIFF_W'(prev_sel);
    abs_err       = data_d.err[ERR_W-1] ? ERR_W'(-data_d.err) : ERR_W'(data_d.err);
    data_d.start  = in_start_i;
    data_d.win    = abs_err < ERR_W'(cfg_i.window);
    data_d.settle = abs_err < ERR_W'(cfg_i.band);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      prev_q  <= '0;
    end else begin
      if (in_ready_o) valid_q <= in_valid_i;
      if (take) prev_q <= data_d.err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) data_q <= data_d;
  end

endmodule

// ----- rtl/core/dpc_mult.sv -----
`timescale 1ns / 1ps
// Stage 2: the three gain multiplies, registered.
// Depends on dpc_pkg.
module dpc_mult import dpc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  input  err_t  in_data_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  output mul_t  out_data_o,
  input  logic  out_ready_i
);

  logic valid_q;
  mul_t data_q, data_d;
  logic take;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    data_d.p      = PROD_P_W'(signed'({1'b0, cfg_i.gain_p})) * PROD_P_W'(in_data_i.err);
    data_d.d      = PROD_D_W'(signed'({1'b0, cfg_i.gain_d})) * PROD_D_W'(in_data_i.diff);
    data_d.ip     = PROD_P_W'(signed'({1'b0, cfg_i.gain_i})) * PROD_P_W'(in_data_i.err);
    data_d.start  = in_data_i.start;
    data_d.win    = in_data_i.win;
    data_d.settle = in_data_i.settle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) data_q <= data_d;
  end

endmodule

// ----- rtl/core/dpc_integ.sv -----
`timescale 1ns / 1ps
// Stage 3: saturating windowed integrator and the P plus D partial sum.
// Holds the integral state. Depends on dpc_pkg.
module dpc_integ import dpc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  mul_t  in_data_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  output acc_t  out_data_o,
  input  logic  out_ready_i
);

  logic                      valid_q;
  acc_t                      data_q, data_d;
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [INTEG_W-1:0] base;
  logic signed [INTEG_W-1:0] sat;
  logic signed [ACC_W-1:0]   acc;
  logic                      take;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    base = in_data_i.start ? '0 : integ_q;
    acc  = ACC_W'(in_data_i.ip) + ACC_W'(base);
    priority if (acc > ACC_W'(INTEG_MAX)) begin
      sat = INTEG_MAX;
    end else if (acc < ACC_W'(INTEG_MIN)) begin
      sat = INTEG_MIN;
    end else begin
      sat = acc[INTEG_W-1:0];
    end
    data_d.integ  = in_data_i.win ? sat : base;
    data_d.pd     = SUM_W'(in_data_i.p) + SUM_W'(in_data_i.d);
    data_d.settle = in_data_i.settle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      integ_q <= '0;
    end else begin
      if (in_ready_o) valid_q <= in_valid_i;
      if (take) integ_q <= data_d.integ;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) data_q <= data_d;
  end

endmodule

// ----- rtl/core/dpc_limit.sv -----
`timescale 1ns / 1ps
// Stage 4: final sum, floor scaling, speed clamp, settle band, done flag.
// Output register of the block. Depends on dpc_pkg.
module dpc_limit import dpc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      in_valid_i,
  input  acc_t                      in_data_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  output logic signed [DRIVE_W-1:0] out_drive_o,
  output logic                      out_done_o,
  input  logic                      out_ready_i
);

  logic                      valid_q;
  logic signed [DRIVE_W-1:0] drive_q, drive_d;
  logic                      done_q, done_d;
  logic signed [SUM_W-1:0]   sum;
  logic signed [DRV_W-1:0]   drv;
  logic signed [DRV_W-1:0]   lim;
  logic signed [DRV_W-1:0]   clamped;
  logic                      take;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_drive_o = drive_q;
  assign out_done_o  = done_q;

  always_comb begin
    sum = in_data_i.pd + SUM_W'(in_data_i.integ);
    drv = sum[SUM_W-1:FRAC_W];
    lim = signed'(DRV_W'({cfg_i.max_speed, {FRAC_W{1'b0}}}));
    priority if (drv > lim) begin
      clamped = lim;
    end else if (drv < -lim) begin
      clamped = -lim;
    end else begin
      clamped = drv;
    end
    drive_d = in_data_i.settle ? '0 : clamped[DRIVE_W-1:0];
    done_d  = (drive_d < ONE_PERCENT) && (drive_d > -ONE_PERCENT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      drive_q <= drive_d;
      done_q  <= done_d;
    end
  end

endmodule

// ----- rtl/core/distance_pid_with_clamp_top.sv -----
`timescale 1ns / 1ps
// Top level of the distance PID controller with integral window and clamp.
// Depends on dpc_pkg, dpc_ifs, dpc_err, dpc_mult, dpc_integ, dpc_limit.
//
// Usage:
//   in_i   (sink)  : one encoder position sample per beat, 1/16 degree,
//                    with start_move to clear integral and previous error.
//   out_o  (source): one beat per sample: drive_level in 1/256 percent
//                    and move_done when |drive_level| is under one percent.
//   cfg_*          : write-only register port, index 0..6, to be written
//                    only while idle; the block itself does not enforce it.
//   Each sample passes the error, multiply, integrator and output registers.
//   Throughput is one sample per cycle unless out_o is held; integrator
//   and previous error each close their loop in one stage: samples stream.
//   Each stage has its own valid and stalls only when it is full and the
//   stage after it is stalled, so bubbles fill while out_o is held.
//   With out_o stalled and all four stages full, in_i.ready drops.
//   Reset clears the pipeline valids, the integral, the previous error and
//   loads the register defaults (gains 1516/0/1229, clamp 100 percent,
//   window 800, band 3, target 0).
module distance_pid_with_clamp_top import dpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dpc_in_if.sink                in_i,
  dpc_out_if.source             out_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target    <= '0;
      cfg_q.gain_p    <= 16'd1516;
      cfg_q.gain_i    <= '0;
      cfg_q.gain_d    <= 16'd1229;
      cfg_q.max_speed <= 7'd100;
      cfg_q.window    <= 23'd800;
      cfg_q.band      <= 23'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TARGET: cfg_q.target    <= signed'(cfg_data_i[POS_W-1:0]);
        REG_GAIN_P: cfg_q.gain_p    <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I: cfg_q.gain_i    <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D: cfg_q.gain_d    <= cfg_data_i[GAIN_W-1:0];
        REG_SPEED:  cfg_q.max_speed <= cfg_data_i[SPEED_W-1:0];
        REG_WINDOW: cfg_q.window    <= cfg_data_i[BAND_W-1:0];
        REG_SETTLE: cfg_q.band      <= cfg_data_i[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  logic  err_valid, err_ready;
  err_t  err_data;
  logic  mul_valid, mul_ready;
  mul_t  mul_data;
  logic  acc_valid, acc_ready;
  acc_t  acc_data;

  dpc_err u_err (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_i.valid),
    .in_position_i (in_i.position),
    .in_start_i    (in_i.start_move),
    .in_ready_o    (in_i.ready),
    .out_valid_o   (err_valid),
    .out_data_o    (err_data),
    .out_ready_i   (err_ready)
  );

  dpc_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (err_valid),
    .in_data_i   (err_data),
    .in_ready_o  (err_ready),
    .out_valid_o (mul_valid),
    .out_data_o  (mul_data),
    .out_ready_i (mul_ready)
  );

  dpc_integ u_integ (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul_valid),
    .in_data_i   (mul_data),
    .in_ready_o  (mul_ready),
    .out_valid_o (acc_valid),
    .out_data_o  (acc_data),
    .out_ready_i (acc_ready)
  );

  dpc_limit u_limit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (acc_valid),
    .in_data_i   (acc_data),
    .in_ready_o  (acc_ready),
    .out_valid_o (out_o.valid),
    .out_drive_o (out_o.drive_level),
    .out_done_o  (out_o.move_done),
    .out_ready_i (out_o.ready)
  );

endmodule

// ----- rtl/core/dpc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for distance_pid_with_clamp_top, bound to the top level.
// Depends on dpc_pkg.
module dpc_checker import dpc_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [DRIVE_W-1:0] drive_level_i,
  input logic                      move_done_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(drive_level_i) && $stable(move_done_i))
    else $error("result payload changed while stalled");

  a_done_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> move_done_i == ((drive_level_i < ONE_PERCENT) &&
                                    (drive_level_i > -ONE_PERCENT)))
    else $error("move_done disagrees with drive_level");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (drive_level_i <= 16'sd32512) && (drive_level_i >= -16'sd32512))
    else $error("drive_level beyond the largest clamp");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !out_valid_i |-> in_ready_i)
    else $error("input stalled with no result waiting");

endmodule

bind distance_pid_with_clamp_top dpc_checker u_dpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .drive_level_i (out_o.drive_level),
  .move_done_i   (out_o.move_done)
);
